[rtl/u8s_pkg.sv]
package u8s_pkg;

  // Input word modes.
  localparam logic MODE_DATA  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Replacement character '?'.
  localparam logic [7:0] REPL_CHAR = 8'h3F;

  // Code point limits.
  localparam logic [20:0] CP_MIN_2B   = 21'h000080;
  localparam logic [20:0] CP_MIN_3B   = 21'h000800;
  localparam logic [20:0] CP_MIN_4B   = 21'h010000;
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_word_t;

  // All result bytes caused by one input word; count is 1 to 4 when stored.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
  } group_t;

  // Outcome of scanning one input word against the held bytes.
  typedef struct packed {
    group_t          grp;
    logic [1:0]      pend_count;
    logic [2:0][7:0] pend_bytes;
  } scan_res_t;

  // Sequence length announced by a lead byte, 0 for a byte that cannot lead.
  function automatic logic [2:0] lead_class(logic [7:0] b);
    logic [2:0] len;
    priority if ((b & 8'h80) == 8'h00) len = 3'd1;
    else if ((b & 8'hE0) == 8'hC0) len = 3'd2;
    else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
    else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
    else len = 3'd0;
    return len;
  endfunction

  function automatic logic is_cont(logic [7:0] b);
    return (b & 8'hC0) == 8'h80;
  endfunction

endpackage

[rtl/u8s_scan.sv]
module u8s_scan (
  input  logic [1:0]          pend_count,
  input  logic [2:0][7:0]     pend_bytes,
  input  u8s_pkg::in_word_t   word,
  output u8s_pkg::scan_res_t  res
);

  // A complete multi-byte sequence is good when all continuation bytes are
  // well formed and the code point is neither overlong, a surrogate nor
  // beyond the Unicode range.
  function automatic logic seq_ok(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                  logic [7:0] b3, logic [2:0] len);
    logic        conts;
    logic        bad;
    logic [20:0] cp;
    unique case (len)
      3'd2: begin
        conts = u8s_pkg::is_cont(b1);
        cp    = {10'd0, b0[4:0], b1[5:0]};
      end
      3'd3: begin
        conts = u8s_pkg::is_cont(b1) && u8s_pkg::is_cont(b2);
        cp    = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      end
      default: begin
        conts = u8s_pkg::is_cont(b1) && u8s_pkg::is_cont(b2) && u8s_pkg::is_cont(b3);
        cp    = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      end
    endcase
    bad = (len == 3'd2 && cp < u8s_pkg::CP_MIN_2B) ||
          (len == 3'd3 && cp < u8s_pkg::CP_MIN_3B) ||
          (len == 3'd4 && cp < u8s_pkg::CP_MIN_4B) ||
          (cp > u8s_pkg::CP_MAX) ||
          (cp >= u8s_pkg::CP_SURR_LO && cp <= u8s_pkg::CP_SURR_HI);
    return conts && !bad;
  endfunction

  // Walks the held bytes plus the new byte from the front. Every step
  // consumes at least one byte, so four steps cover the whole buffer.
  function automatic u8s_pkg::scan_res_t scan_fn(logic [1:0] pc, logic [2:0][7:0] pb,
                                                 u8s_pkg::in_word_t w);
    u8s_pkg::scan_res_t r;
    logic [3:0][7:0]    buf_b;
    logic               flush;
    logic               stop;
    logic               ok;
    logic [2:0]         n;
    logic [2:0]         i;
    logic [2:0]         k;
    logic [2:0]         len;
    logic [7:0]         b0;
    int                 s;
    int                 j;
    int                 m;
    flush = (w.mode == u8s_pkg::MODE_FLUSH);
    for (m = 0; m < 4; m++) begin
      if (m < 3 && 2'(m) < pc) buf_b[2'(m)] = pb[2'(m)];
      else buf_b[2'(m)] = w.data_byte;
    end
    n     = {1'b0, pc} + (flush ? 3'd0 : 3'd1);
    r     = '0;
    r.pend_bytes = pb;
    i     = 3'd0;
    k     = 3'd0;
    stop  = 1'b0;
    for (s = 0; s < 4; s++) begin
      if (!stop && i < n) begin
        b0  = buf_b[i[1:0]];
        len = u8s_pkg::lead_class(b0);
        if (len <= 3'd1) begin
          r.grp.bytes[k[1:0]] = (len == 3'd0) ? u8s_pkg::REPL_CHAR : b0;
          k = k + 3'd1;
          i = i + 3'd1;
        end else if (i + len > n) begin
          if (flush) begin
            r.grp.bytes[k[1:0]] = u8s_pkg::REPL_CHAR;
            k = k + 3'd1;
          end else begin
            r.pend_count = 2'(n - i);
            for (m = 0; m < 3; m++) begin
              if (i + 3'(m) < 3'd4) r.pend_bytes[2'(m)] = buf_b[2'(i + 3'(m))];
            end
          end
          stop = 1'b1;
        end else begin
          ok = seq_ok(b0, buf_b[2'(i + 3'd1)], buf_b[2'(i + 3'd2)],
                      buf_b[2'(i + 3'd3)], len);
          if (!ok) begin
            r.grp.bytes[k[1:0]] = u8s_pkg::REPL_CHAR;
            k = k + 3'd1;
            i = i + 3'd1;
          end else begin
            for (j = 0; j < 4; j++) begin
              if (3'(j) < len) begin
                r.grp.bytes[k[1:0]] = buf_b[2'(i + 3'(j))];
                k = k + 3'd1;
              end
            end
            i = i + len;
          end
        end
      end
    end
    r.grp.count = k;
    return r;
  endfunction

  assign res = scan_fn(pend_count, pend_bytes, word);

endmodule

[rtl/u8s_res_fifo.sv]
module u8s_res_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  u8s_pkg::group_t     push_grp,
  output logic                full,
  output logic                clean_valid,
  input  logic                clean_ready,
  output u8s_pkg::out_word_t  clean_data
);

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  u8s_pkg::group_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [1:0]        sub;
  u8s_pkg::group_t   head;
  logic              last;
  logic              pop;

  assign head        = mem[rd_ptr];
  assign full        = (fill == FILL_W'(DEPTH));
  assign clean_valid = (fill != '0);
  assign last        = ({1'b0, sub} + 3'd1 == head.count);
  assign pop         = clean_valid && clean_ready && last;

  assign clean_data.out_byte    = head.bytes[sub];
  assign clean_data.last_of_run = last;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_grp;
    end
  end

  always_comb begin
    unique case ({push, pop})
      2'b10:   fill_next = fill + FILL_W'(1);
      2'b01:   fill_next = fill - FILL_W'(1);
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      sub    <= '0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
        sub    <= '0;
      end else if (clean_valid && clean_ready) begin
        sub <= sub + 2'd1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("result queue fill count beyond its depth");

  a_sub_in_group: assert property (@(posedge clk) disable iff (rst)
    clean_valid |-> ({1'b0, sub} < head.count))
    else $error("byte index past the end of the head group");

  a_push_group: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full && push_grp.count != 3'd0 && push_grp.count <= 3'd4))
    else $error("bad push into the result queue");

  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> fill == FILL_W'($past(fill) + FILL_W'(1)))
    else $error("fill count did not follow a push");
`endif

endmodule

[rtl/utf8_stream_sanitizer_core.sv]
// UTF-8 stream sanitizer. Each input word carries one raw byte, or a flush
// that marks the end of the stream. Valid UTF-8 sequences pass through
// unchanged; a byte that cannot lead a sequence, a sequence with a broken
// continuation byte, and an overlong, surrogate or out-of-range sequence
// each give '?' (0x3F) for the lead byte, after which the following bytes
// are examined again on their own. An unfinished sequence of up to three
// bytes is held until its full length has arrived. A flush gives one '?'
// if bytes are held and empties the holding buffer. One input word causes
// zero to four output words; last_of_run marks the final one. An input word
// is taken in every cycle while the result queue has a free slot: the whole
// scan of the held bytes plus the new byte is done in the accepting cycle,
// and its results are stored as one group in a queue of GROUP_DEPTH
// entries. Output words leave at one per cycle while clean_ready is high,
// so the sustained rate is one input word per cycle as long as input
// words average at most one output word each and the output does not
// stall; a burst of several output words after a resync drains at the
// output rate. Each group is registered in the queue before it is sent.
module utf8_stream_sanitizer_core #(
  parameter int GROUP_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                raw_valid,
  output logic                raw_ready,
  input  u8s_pkg::in_word_t   raw_data,
  output logic                clean_valid,
  input  logic                clean_ready,
  output u8s_pkg::out_word_t  clean_data
);

  // Holding buffer for an unfinished sequence. Only the entries below
  // pending_count are ever read, so the bytes themselves carry no reset.
  logic [2:0][7:0]     pending_bytes;
  logic [1:0]          pending_count;

  u8s_pkg::scan_res_t  scan;
  logic                full;
  logic                accept;
  logic                push;

  u8s_scan u_scan (
    .pend_count (pending_count),
    .pend_bytes (pending_bytes),
    .word       (raw_data),
    .res        (scan)
  );

  // The scan result goes straight into the queue, so the state for the next
  // word is ready in the next cycle no matter how the output side stalls.
  assign raw_ready = !full;
  assign accept    = raw_valid && raw_ready;
  assign push      = accept && (scan.grp.count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 2'd0;
    end else if (accept) begin
      pending_count <= scan.pend_count;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pending_bytes <= scan.pend_bytes;
    end
  end

  u8s_res_fifo #(
    .DEPTH (GROUP_DEPTH)
  ) u_res_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_grp    (scan.grp),
    .full        (full),
    .clean_valid (clean_valid),
    .clean_ready (clean_ready),
    .clean_data  (clean_data)
  );

`ifndef ASSERT_OFF
  // A held sequence always starts with a multi-byte lead that announces
  // more bytes than are held.
  a_pending_lead: assert property (@(posedge clk) disable iff (rst)
    (pending_count != 2'd0) |->
      (u8s_pkg::lead_class(pending_bytes[0]) > {1'b0, pending_count}))
    else $error("held bytes do not start with an unfinished lead");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && raw_data.mode == u8s_pkg::MODE_FLUSH) |=> (pending_count == 2'd0))
    else $error("flush left bytes in the holding buffer");

  a_ascii_pass: assert property (@(posedge clk) disable iff (rst)
    (accept && raw_data.mode == u8s_pkg::MODE_DATA && pending_count == 2'd0 &&
     !raw_data.data_byte[7]) |->
      (scan.grp.count == 3'd1 && scan.grp.bytes[0] == raw_data.data_byte))
    else $error("plain ASCII byte was not passed through alone");
`endif

endmodule
